[rtl/core/itpc_pkg.sv]
// ----------------------------------------------------------------------------
// itpc_pkg
// Shared types, codes and character tables of the infix to postfix converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itpc_pkg;

  // Operator codes held on the stack
  localparam logic [2:0] CODE_OPEN = 3'd0;
  localparam logic [2:0] CODE_ADD  = 3'd1;
  localparam logic [2:0] CODE_SUB  = 3'd2;
  localparam logic [2:0] CODE_MUL  = 3'd3;
  localparam logic [2:0] CODE_DIV  = 3'd4;
  localparam logic [2:0] CODE_MOD  = 3'd5;
  localparam logic [2:0] CODE_POW  = 3'd6;
  localparam logic [2:0] CODE_NONE = 3'd7;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_MOD   = 8'h25;
  localparam logic [7:0] CH_POW   = 8'h5E;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_UNMATCH  = 2'd2;
  localparam logic [1:0] ST_INVALID  = 2'd3;

  typedef enum logic [2:0] {
    CLS_END,
    CLS_ALNUM,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OP,
    CLS_BAD
  } cls_t;

  typedef enum logic [1:0] {
    OSEL_SYM,
    OSEL_PEND,
    OSEL_ZERO
  } osel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASS,
    S_ONE,
    S_RD,
    S_CHK,
    S_FLUSH,
    S_FIN
  } state_t;

  typedef struct packed {
    logic       load_sym;
    logic       rd;
    logic       pop;
    logic       push;
    logic       open_inc;
    logic       open_dec;
    logic       open_clr;
    logic       pend_load;
    logic       pend_clr;
    logic       out_load;
    osel_t      out_sel;
    logic [1:0] out_status;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    cls_t cls;
    logic count_zero;
    logic count_one;
    logic count_full;
    logic open_zero;
    logic top_open;
    logic top_pops;
    logic pend_valid;
    logic out_free;
  } stat_t;

  function automatic logic [2:0] sym_code(input logic [7:0] c);
    logic [2:0] r;
    unique case (c)
      CH_OPEN: r = CODE_OPEN;
      CH_ADD:  r = CODE_ADD;
      CH_SUB:  r = CODE_SUB;
      CH_MUL:  r = CODE_MUL;
      CH_DIV:  r = CODE_DIV;
      CH_MOD:  r = CODE_MOD;
      CH_POW:  r = CODE_POW;
      default: r = CODE_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] code_char(input logic [2:0] code);
    logic [7:0] r;
    unique case (code)
      CODE_OPEN: r = CH_OPEN;
      CODE_ADD:  r = CH_ADD;
      CODE_SUB:  r = CH_SUB;
      CODE_MUL:  r = CH_MUL;
      CODE_DIV:  r = CH_DIV;
      CODE_MOD:  r = CH_MOD;
      CODE_POW:  r = CH_POW;
      default:   r = CH_NUL;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] code_prec(input logic [2:0] code);
    logic [2:0] r;
    unique case (code)
      CODE_OPEN:                     r = 3'd1;
      CODE_ADD, CODE_SUB:            r = 3'd2;
      CODE_MUL, CODE_DIV, CODE_MOD:  r = 3'd3;
      CODE_POW:                      r = 3'd4;
      default:                       r = 3'd0;
    endcase
    return r;
  endfunction

  // Stacked operator must leave before the incoming one is pushed
  function automatic logic pops_before(input logic [2:0] top, input logic [2:0] incoming);
    logic [2:0] pt;
    logic [2:0] pi;
    pt = code_prec(top);
    pi = code_prec(incoming);
    if (top == CODE_OPEN) return 1'b0;
    if (pt > pi) return 1'b1;
    return (pt == pi) && (incoming != CODE_POW);
  endfunction

  function automatic cls_t classify(input logic [7:0] c);
    cls_t r;
    if (c == CH_NUL) r = CLS_END;
    else if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A)) r = CLS_ALNUM;
    else if (c == CH_OPEN) r = CLS_OPEN;
    else if (c == CH_CLOSE) r = CLS_CLOSE;
    else if (sym_code(c) != CODE_NONE) r = CLS_OP;
    else r = CLS_BAD;
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/infix_to_postfix_converter_unit.sv]
// A letter, digit, invalid symbol or overflowed '(' gives one word; a stacked '(' gives
// none. An operator or ')' pops, one by one, each stacked operator that must leave;
// ')' then drops its '('. The end symbol pops every stacked entry, then gives the
// terminator word. Output stalls hold the unit back. One symbol is taken at a time.
// Synchronous reset empties the stack and drops any held output word; stack memory
// contents are not cleared.
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit
// Shunting-yard infix to postfix converter with operator stack and status words.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_to_postfix_converter_unit #(
  parameter int STACK_DEPTH = 32
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire  [7:0] symbol,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [7:0] out_char,
  output logic [1:0] status,
  output logic       last
);

  itpc_pkg::cmd_t  cmd;
  itpc_pkg::stat_t stat;

  itpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  itpc_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .symbol    (symbol),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .status    (status),
    .last      (last)
  );

endmodule

`default_nettype wire

[rtl/core/itpc_dp.sv]
// ----------------------------------------------------------------------------
// itpc_dp
// Datapath: symbol register, operator stack memory, counters, pending word
// and output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module itpc_dp #(
  parameter int STACK_DEPTH = 32
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire  [7:0]          symbol,
  input  itpc_pkg::cmd_t      cmd,
  output itpc_pkg::stat_t     stat,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [7:0]          out_char,
  output logic [1:0]          status,
  output logic                last
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [2:0]    stack_mem [STACK_DEPTH];
  logic [7:0]    sym;
  logic [CW-1:0] count;
  logic [CW-1:0] open_count;
  logic [2:0]    rd_code;
  logic [7:0]    pend_char;
  logic          pend_valid;
  logic [CW-1:0] count_dec;
  logic [2:0]    sym_cd;

  assign count_dec = count - CW'(1);
  assign sym_cd    = itpc_pkg::sym_code(sym);

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[count[AW-1:0]] <= sym_cd;
    end
    if (cmd.rd) begin
      rd_code <= stack_mem[count_dec[AW-1:0]];
    end
    if (cmd.load_sym) begin
      sym <= symbol;
    end
    if (cmd.pend_load) begin
      pend_char <= itpc_pkg::code_char(rd_code);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      open_count <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.push) count <= count + CW'(1);
      else if (cmd.pop) count <= count_dec;
      if (cmd.open_clr) open_count <= '0;
      else if (cmd.open_inc) open_count <= open_count + CW'(1);
      else if (cmd.open_dec) open_count <= open_count - CW'(1);
      if (cmd.pend_clr) pend_valid <= 1'b0;
      else if (cmd.pend_load) pend_valid <= 1'b1;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (cmd.out_sel)
        itpc_pkg::OSEL_SYM:  out_char <= sym;
        itpc_pkg::OSEL_PEND: out_char <= pend_char;
        itpc_pkg::OSEL_ZERO: out_char <= itpc_pkg::CH_NUL;
        default:             out_char <= itpc_pkg::CH_NUL;
      endcase
      status <= cmd.out_status;
      last   <= cmd.out_last;
    end
  end

  always_comb begin
    stat.cls        = itpc_pkg::classify(sym);
    stat.count_zero = (count == '0);
    stat.count_one  = (count == CW'(1));
    stat.count_full = (count == CW'(STACK_DEPTH));
    stat.open_zero  = (open_count == '0);
    stat.top_open   = (rd_code == itpc_pkg::CODE_OPEN);
    stat.top_pops   = itpc_pkg::pops_before(rd_code, sym_cd);
    stat.pend_valid = pend_valid;
    stat.out_free   = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

[rtl/core/itpc_ctrl.sv]
// ----------------------------------------------------------------------------
// itpc_ctrl
// Controller: sequences classification, stack pops, pushes and word output.
// ----------------------------------------------------------------------------
`default_nettype none

module itpc_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  itpc_pkg::stat_t     stat,
  output itpc_pkg::cmd_t      cmd
);

  itpc_pkg::state_t state;
  itpc_pkg::state_t state_next;

  logic is_end;
  logic is_close;
  logic is_op;
  logic do_pop;
  logic need_pend;

  assign is_end    = (stat.cls == itpc_pkg::CLS_END);
  assign is_close  = (stat.cls == itpc_pkg::CLS_CLOSE);
  assign is_op     = (stat.cls == itpc_pkg::CLS_OP);
  assign do_pop    = is_end || (is_close && !stat.top_open) || (is_op && stat.top_pops);
  assign need_pend = do_pop && !(is_end && stat.top_open);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itpc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      itpc_pkg::S_IDLE: begin
        if (in_valid) state_next = itpc_pkg::S_CLASS;
      end
      itpc_pkg::S_CLASS: begin
        unique case (stat.cls)
          itpc_pkg::CLS_END,
          itpc_pkg::CLS_OP:    state_next = stat.count_zero ? itpc_pkg::S_FIN : itpc_pkg::S_RD;
          itpc_pkg::CLS_OPEN:  state_next = stat.count_full ? itpc_pkg::S_ONE : itpc_pkg::S_IDLE;
          itpc_pkg::CLS_CLOSE: state_next = stat.open_zero ? itpc_pkg::S_ONE : itpc_pkg::S_RD;
          default:             state_next = itpc_pkg::S_ONE;
        endcase
      end
      itpc_pkg::S_ONE: begin
        if (stat.out_free) state_next = itpc_pkg::S_IDLE;
      end
      itpc_pkg::S_RD: begin
        state_next = itpc_pkg::S_CHK;
      end
      itpc_pkg::S_CHK: begin
        priority if (need_pend && stat.pend_valid) state_next = itpc_pkg::S_FLUSH;
        else if (do_pop) state_next = stat.count_one ? itpc_pkg::S_FIN : itpc_pkg::S_RD;
        else state_next = itpc_pkg::S_FIN;
      end
      itpc_pkg::S_FLUSH: begin
        if (stat.out_free) state_next = itpc_pkg::S_CHK;
      end
      itpc_pkg::S_FIN: begin
        priority if (is_end) begin
          if (!stat.pend_valid && stat.out_free) state_next = itpc_pkg::S_IDLE;
        end else if (is_close || is_op) begin
          if (!stat.pend_valid && !(is_op && stat.count_full)) state_next = itpc_pkg::S_IDLE;
          else if (stat.out_free) state_next = itpc_pkg::S_IDLE;
        end else begin
          state_next = itpc_pkg::S_IDLE;
        end
      end
      default: state_next = itpc_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd            = '0;
    cmd.out_sel    = itpc_pkg::OSEL_SYM;
    cmd.out_status = itpc_pkg::ST_OK;
    in_ready       = 1'b0;
    unique case (state)
      itpc_pkg::S_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_sym = in_valid;
      end
      itpc_pkg::S_CLASS: begin
        if (stat.cls == itpc_pkg::CLS_OPEN && !stat.count_full) begin
          cmd.push     = 1'b1;
          cmd.open_inc = 1'b1;
        end
      end
      itpc_pkg::S_ONE: begin
        cmd.out_load = stat.out_free;
        cmd.out_sel  = itpc_pkg::OSEL_SYM;
        cmd.out_last = 1'b1;
        unique case (stat.cls)
          itpc_pkg::CLS_OPEN:  cmd.out_status = itpc_pkg::ST_OVERFLOW;
          itpc_pkg::CLS_CLOSE: cmd.out_status = itpc_pkg::ST_UNMATCH;
          itpc_pkg::CLS_BAD:   cmd.out_status = itpc_pkg::ST_INVALID;
          default:             cmd.out_status = itpc_pkg::ST_OK;
        endcase
      end
      itpc_pkg::S_RD: begin
        cmd.rd = 1'b1;
      end
      itpc_pkg::S_CHK: begin
        if (do_pop && !(need_pend && stat.pend_valid)) begin
          cmd.pop       = 1'b1;
          cmd.pend_load = need_pend;
        end
      end
      itpc_pkg::S_FLUSH: begin
        cmd.out_load = stat.out_free;
        cmd.out_sel  = itpc_pkg::OSEL_PEND;
        cmd.pend_clr = stat.out_free;
      end
      itpc_pkg::S_FIN: begin
        priority if (is_end) begin
          // drained: flush the held word, then the terminator
          cmd.out_load = stat.out_free;
          if (stat.pend_valid) begin
            cmd.out_sel  = itpc_pkg::OSEL_PEND;
            cmd.pend_clr = stat.out_free;
          end else begin
            cmd.out_sel  = itpc_pkg::OSEL_ZERO;
            cmd.out_last = 1'b1;
            cmd.open_clr = stat.out_free;
          end
        end else if (is_close) begin
          // top holds the matching open paren
          if (!stat.pend_valid) begin
            cmd.pop      = 1'b1;
            cmd.open_dec = 1'b1;
          end else if (stat.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = itpc_pkg::OSEL_PEND;
            cmd.out_last = 1'b1;
            cmd.pend_clr = 1'b1;
            cmd.pop      = 1'b1;
            cmd.open_dec = 1'b1;
          end
        end else if (is_op) begin
          if (stat.pend_valid) begin
            if (stat.out_free) begin
              cmd.out_load = 1'b1;
              cmd.out_sel  = itpc_pkg::OSEL_PEND;
              cmd.out_last = 1'b1;
              cmd.pend_clr = 1'b1;
              cmd.push     = 1'b1;
            end
          end else if (stat.count_full) begin
            cmd.out_load   = stat.out_free;
            cmd.out_sel    = itpc_pkg::OSEL_SYM;
            cmd.out_status = itpc_pkg::ST_OVERFLOW;
            cmd.out_last   = 1'b1;
          end else begin
            cmd.push = 1'b1;
          end
        end else begin
          cmd.out_load = 1'b0;
        end
      end
      default: begin
        cmd.out_load = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for infix_to_postfix_converter_unit: a short table of
// directed symbols, then random expressions (well formed, deeply nested,
// broken and noise). A shunting-yard predictor gives every word that the table
// leaves out; each is checked field by field under random idling on both sides.
// ----------------------------------------------------------------------------

module tb;

  localparam int STACK_DEPTH  = 32;
  localparam int NUM_ITEMS    = 380;
  localparam int QUIET_CYCLES = 150;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct packed {
    logic [7:0] ch;
    logic [1:0] st;
    logic       lst;
  } word_t;

  typedef struct packed {
    logic [7:0] sym;
    logic       typed;
    logic [7:0] ch;
    logic [1:0] st;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] symbol = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char;
  logic [1:0] status;
  logic       last;

  word_t       expected_words[$];
  logic [2:0]  op_mem [STACK_DEPTH];
  int unsigned op_depth;
  int          err_count = 0;
  int          cycle_count = 0;
  int          sent_count = 0;
  int          words_seen = 0;
  int          ovf_seen = 0;
  int          unm_seen = 0;
  int          bad_seen = 0;
  int          rx_hold = 0;
  bit          quiet = 1'b0;
  bit          mid_done = 1'b0;

  logic [7:0] op_chars [6] = '{itpc_pkg::CH_ADD, itpc_pkg::CH_SUB, itpc_pkg::CH_MUL,
                               itpc_pkg::CH_DIV, itpc_pkg::CH_MOD, itpc_pkg::CH_POW};

  dir_row_t dir_rows [0:26] = '{
    '{itpc_pkg::CH_NUL,   1'b1, itpc_pkg::CH_NUL,   itpc_pkg::ST_OK},
    '{"0",                1'b1, "0",                itpc_pkg::ST_OK},
    '{"z",                1'b1, "z",                itpc_pkg::ST_OK},
    '{itpc_pkg::CH_CLOSE, 1'b1, itpc_pkg::CH_CLOSE, itpc_pkg::ST_UNMATCH},
    '{8'h23,              1'b1, 8'h23,              itpc_pkg::ST_INVALID},
    '{8'hFF,              1'b1, 8'hFF,              itpc_pkg::ST_INVALID},
    '{8'h20,              1'b1, 8'h20,              itpc_pkg::ST_INVALID},
    '{itpc_pkg::CH_OPEN,  1'b0, 8'h00,              itpc_pkg::ST_OK},
    '{"a",                1'b0, 8'h00,              itpc_pkg::ST_OK},
    '{itpc_pkg::CH_ADD,   1'b0, 8'h00,              itpc_pkg::ST_OK},
    '{"b",                1'b0, 8'h00,              itpc_pkg::ST_OK},
    '{itpc_pkg::CH_CLOSE, 1'b0, 8'h00,              itpc_pkg::ST_OK},
    '{itpc_pkg::CH_MUL,   1'b0, 8'h00,              itpc_pkg::ST_OK},
    '{"c",                1'b0, 8'h00,              itpc_pkg::ST_OK},
    '{itpc_pkg::CH_POW,   1'b0, 8'h00,              itpc_pkg::ST_OK},
    '{"d",                1'b0, 8'h00,              itpc_pkg::ST_OK},
    '{itpc_pkg::CH_POW,   1'b0, 8'h00,              itpc_pkg::ST_OK},
    '{"e",                1'b0, 8'h00,              itpc_pkg::ST_OK},
    '{itpc_pkg::CH_SUB,   1'b0, 8'h00,              itpc_pkg::ST_OK},
    '{"f",                1'b0, 8'h00,              itpc_pkg::ST_OK},
    '{itpc_pkg::CH_DIV,   1'b0, 8'h00,              itpc_pkg::ST_OK},
    '{"g",                1'b0, 8'h00,              itpc_pkg::ST_OK},
    '{itpc_pkg::CH_MOD,   1'b0, 8'h00,              itpc_pkg::ST_OK},
    '{"h",                1'b0, 8'h00,              itpc_pkg::ST_OK},
    '{itpc_pkg::CH_NUL,   1'b0, 8'h00,              itpc_pkg::ST_OK},
    '{itpc_pkg::CH_OPEN,  1'b0, 8'h00,              itpc_pkg::ST_OK},
    '{itpc_pkg::CH_NUL,   1'b0, 8'h00,              itpc_pkg::ST_OK}
  };

  infix_to_postfix_converter_unit #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .symbol   (symbol),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_char (out_char),
    .status   (status),
    .last     (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---- shunting-yard predictor ----

  function automatic bit is_alnum(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic [2:0] glyph_code(input logic [7:0] c);
    case (c)
      itpc_pkg::CH_OPEN: return itpc_pkg::CODE_OPEN;
      itpc_pkg::CH_ADD:  return itpc_pkg::CODE_ADD;
      itpc_pkg::CH_SUB:  return itpc_pkg::CODE_SUB;
      itpc_pkg::CH_MUL:  return itpc_pkg::CODE_MUL;
      itpc_pkg::CH_DIV:  return itpc_pkg::CODE_DIV;
      itpc_pkg::CH_MOD:  return itpc_pkg::CODE_MOD;
      itpc_pkg::CH_POW:  return itpc_pkg::CODE_POW;
      default:           return itpc_pkg::CODE_NONE;
    endcase
  endfunction

  function automatic logic [7:0] code_glyph(input logic [2:0] k);
    case (k)
      itpc_pkg::CODE_OPEN: return itpc_pkg::CH_OPEN;
      itpc_pkg::CODE_ADD:  return itpc_pkg::CH_ADD;
      itpc_pkg::CODE_SUB:  return itpc_pkg::CH_SUB;
      itpc_pkg::CODE_MUL:  return itpc_pkg::CH_MUL;
      itpc_pkg::CODE_DIV:  return itpc_pkg::CH_DIV;
      itpc_pkg::CODE_MOD:  return itpc_pkg::CH_MOD;
      itpc_pkg::CODE_POW:  return itpc_pkg::CH_POW;
      default:             return itpc_pkg::CH_NUL;
    endcase
  endfunction

  function automatic int rank(input logic [2:0] k);
    case (k)
      itpc_pkg::CODE_OPEN:                                        return 1;
      itpc_pkg::CODE_ADD, itpc_pkg::CODE_SUB:                     return 2;
      itpc_pkg::CODE_MUL, itpc_pkg::CODE_DIV, itpc_pkg::CODE_MOD: return 3;
      itpc_pkg::CODE_POW:                                         return 4;
      default:                                                    return 0;
    endcase
  endfunction

  // '^' is right-associative, so an incoming '^' leaves a stacked '^' alone
  function automatic bit yields_to(input logic [2:0] top, input logic [2:0] inc);
    if (top == itpc_pkg::CODE_OPEN) return 1'b0;
    if (rank(top) > rank(inc)) return 1'b1;
    return (rank(top) == rank(inc)) && (inc != itpc_pkg::CODE_POW);
  endfunction

  task automatic shunt_symbol(input logic [7:0] s, input bit record);
    word_t       got[$];
    int unsigned j;
    logic [2:0]  k;
    k = glyph_code(s);
    if (s == itpc_pkg::CH_NUL) begin
      while (op_depth > 0) begin
        op_depth--;
        if (op_mem[op_depth] != itpc_pkg::CODE_OPEN)
          got.push_back('{code_glyph(op_mem[op_depth]), itpc_pkg::ST_OK, 1'b0});
      end
      got.push_back('{itpc_pkg::CH_NUL, itpc_pkg::ST_OK, 1'b0});
    end else if (is_alnum(s)) begin
      got.push_back('{s, itpc_pkg::ST_OK, 1'b0});
    end else if (s == itpc_pkg::CH_OPEN) begin
      if (op_depth >= STACK_DEPTH) begin
        got.push_back('{s, itpc_pkg::ST_OVERFLOW, 1'b0});
      end else begin
        op_mem[op_depth] = itpc_pkg::CODE_OPEN;
        op_depth++;
      end
    end else if (s == itpc_pkg::CH_CLOSE) begin
      j = op_depth;
      while (j > 0 && op_mem[j-1] != itpc_pkg::CODE_OPEN) j--;
      if (j == 0) begin
        got.push_back('{s, itpc_pkg::ST_UNMATCH, 1'b0});
      end else begin
        while (op_depth > j) begin
          op_depth--;
          got.push_back('{code_glyph(op_mem[op_depth]), itpc_pkg::ST_OK, 1'b0});
        end
        op_depth--;
      end
    end else if (k != itpc_pkg::CODE_NONE) begin
      j = op_depth;
      while (j > 0 && yields_to(op_mem[j-1], k)) j--;
      if (j >= STACK_DEPTH) begin
        got.push_back('{s, itpc_pkg::ST_OVERFLOW, 1'b0});
      end else begin
        while (op_depth > j) begin
          op_depth--;
          got.push_back('{code_glyph(op_mem[op_depth]), itpc_pkg::ST_OK, 1'b0});
        end
        op_mem[op_depth] = k;
        op_depth++;
      end
    end else begin
      got.push_back('{s, itpc_pkg::ST_INVALID, 1'b0});
    end
    if (got.size() > 0) got[got.size()-1].lst = 1'b1;
    if (record) foreach (got[i]) expected_words.push_back(got[i]);
  endtask

  // ---- sender ----

  task automatic send_symbol(input logic [7:0] s, input bit typed = 1'b0,
                             input word_t w = '0);
    int gap;
    in_valid <= 1'b1;
    symbol   <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (typed) begin
      shunt_symbol(s, 1'b0);
      expected_words.push_back(w);
    end else begin
      shunt_symbol(s, 1'b1);
    end
    sent_count++;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_words();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("A" + r - 10);
    return 8'("a" + r - 36);
  endfunction

  task automatic run_expression();
    int mode;
    int terms;
    int depth;
    mode  = $urandom_range(0, 9);
    quiet = ($urandom_range(0, 4) == 0);
    if (mode == 0) begin
      repeat ($urandom_range(1, 6)) send_symbol(8'($urandom_range(0, 255)));
    end else if (mode == 1) begin
      // nest close to and past the stack limit
      repeat ($urandom_range(28, 34)) send_symbol(itpc_pkg::CH_OPEN);
      repeat ($urandom_range(2, 8)) begin
        if ($urandom_range(0, 1)) send_symbol(op_chars[$urandom_range(0, 5)]);
        else if ($urandom_range(0, 3) == 0) send_symbol(itpc_pkg::CH_CLOSE);
        else send_symbol(pick_alnum());
      end
      send_symbol(itpc_pkg::CH_NUL);
    end else begin
      terms = $urandom_range(1, 8);
      depth = 0;
      for (int t = 0; t < terms; t++) begin
        while ($urandom_range(0, 3) == 0 && depth < 6) begin
          send_symbol(itpc_pkg::CH_OPEN);
          depth++;
        end
        send_symbol(pick_alnum());
        if ($urandom_range(0, 19) == 0) send_symbol(8'($urandom_range(0, 255)));
        while (depth > 0 && $urandom_range(0, 2) == 0) begin
          send_symbol(itpc_pkg::CH_CLOSE);
          depth--;
        end
        if (t != terms - 1) send_symbol(op_chars[$urandom_range(0, 5)]);
      end
      if ($urandom_range(0, 4) != 0) begin
        while (depth > 0) begin
          send_symbol(itpc_pkg::CH_CLOSE);
          depth--;
        end
      end
      if ($urandom_range(0, 9) == 0) send_symbol(itpc_pkg::CH_CLOSE);
      send_symbol(itpc_pkg::CH_NUL);
    end
  endtask

  // ---- receiver and checker ----

  always @(posedge clk) begin
    word_t w;
    int    hold;
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold   <= 0;
    end else begin
      if (out_valid && out_ready) begin
        words_seen++;
        case (status)
          itpc_pkg::ST_OVERFLOW: ovf_seen++;
          itpc_pkg::ST_UNMATCH:  unm_seen++;
          itpc_pkg::ST_INVALID:  bad_seen++;
          default: ;
        endcase
        if (expected_words.size() == 0) begin
          err_count++;
          $display("%0t unexpected word: char %h status %0d last %0d",
                   $time, out_char, status, last);
        end else begin
          w = expected_words.pop_front();
          if (w.ch !== out_char || w.st !== status || w.lst !== last) begin
            err_count++;
            $display("%0t word mismatch: expected char %h status %0d last %0d, %s %h %s %0d %s %0d",
                     $time, w.ch, w.st, w.lst, "got char", out_char, "status", status,
                     "last", last);
          end
        end
      end
      if (out_ready) begin
        if (out_valid) begin
          hold = quiet ? 0 : $urandom_range(0, 3);
          rx_hold <= hold;
          if (hold > 0) out_ready <= 1'b0;
        end
      end else begin
        if (rx_hold <= 1) out_ready <= 1'b1;
        rx_hold <= rx_hold - 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding",
               cycle_count, expected_words.size());
      $display("infix_to_postfix_converter_unit test failed");
      $finish;
    end
  end

  // ---- main sequence ----

  initial begin
    op_depth = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_symbol(dir_rows[i].sym, dir_rows[i].typed,
                  '{dir_rows[i].ch, dir_rows[i].st, 1'b1});
    drain_words();

    while (sent_count < NUM_ITEMS) begin
      if (!mid_done && sent_count >= NUM_ITEMS / 2) begin
        drain_words();
        mid_done = 1'b1;
      end
      run_expression();
    end
    quiet = 1'b0;
    drain_words();

    if (expected_words.size() != 0) begin
      err_count++;
      $display("%0t %0d expected words never arrived", $time, expected_words.size());
    end
    $display("sent %0d symbols, checked %0d words in %0d cycles", sent_count, words_seen,
             cycle_count);
    $display("status words seen: %0d overflow, %0d unmatched close, %0d invalid",
             ovf_seen, unm_seen, bad_seen);
    if (err_count == 0) begin
      $display("infix_to_postfix_converter_unit test passed");
    end else begin
      $display("infix_to_postfix_converter_unit test failed");
    end
    $finish;
  end

endmodule
